### hw/rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int WIN_DEPTH = 64;                 // window bytes
  localparam int IDX_W     = $clog2(WIN_DEPTH);  // window index
  localparam int CNT_W     = IDX_W + 1;          // fill count, holds WIN_DEPTH
  localparam int Q_DEPTH   = 4;                  // input queue entries
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h27;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hA5;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } sync_cfg_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] fill;
  } eng_stat_t;

endpackage

### hw/rtl/sld_if.sv
// ----------------------------------------------------------------------------
// sld_if
// Valid/ready channels: received bytes in, frame bytes out.
// ----------------------------------------------------------------------------
interface rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_position;
  logic       last_byte;

  modport source (output valid, output frame_byte, output byte_position,
                  output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input last_byte, output ready);
endinterface

### hw/rtl/sld_fifo.sv
// ----------------------------------------------------------------------------
// sld_fifo
// Front end: short byte queue that takes received items while the window
// engine is busy scanning or emitting.
// ----------------------------------------------------------------------------
module sld_fifo import sld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rx_if.sink         in_ch,
  output logic       q_valid,
  output logic [7:0] q_byte,
  input  logic       q_take
);

  logic [7:0]         q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               push;
  logic               pop;

  assign in_ch.ready = (count != Q_DEPTH[Q_PTR_W:0]);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_take && q_valid;
  assign q_valid     = (count != '0);
  assign q_byte      = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/sld_engine.sv
// ----------------------------------------------------------------------------
// sld_engine
// Back end: circular byte window, backward frame scan with running XOR,
// and frame emission through an output register.
// ----------------------------------------------------------------------------
module sld_engine import sld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sync_cfg_t  cfg,
  input  logic       q_valid,
  input  logic [7:0] q_byte,
  output logic       q_take,
  frame_if.source    out_ch,
  output eng_stat_t  stat
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_RD   = 4'b0100,
    ST_WR   = 4'b1000
  } state_t;

  state_t           state;
  logic [7:0]       win [WIN_DEPTH];
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  // scan
  logic [IDX_W-1:0] iss_j;
  logic             iss_more;
  logic             dv;
  logic [IDX_W-1:0] dj;
  logic [7:0]       b0, b1, b2, acc;
  logic             found;
  logic [IDX_W-1:0] start;
  logic [CNT_W-1:0] span;
  logic             match;
  logic             full;

  // emit
  logic [IDX_W-1:0] k;
  logic             k_last;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic [5:0]       out_pos;
  logic             out_last;

  assign full    = (fill == CNT_W'(WIN_DEPTH));
  assign q_take  = (state == ST_IDLE);
  assign wr_addr = full ? head : head + fill[IDX_W-1:0];
  assign rd_addr = (state == ST_SCAN) ? head + iss_j : head + start + k;

  // candidate start dj: sync pair, length byte, XOR of bytes after it is zero
  assign span  = fill - {1'b0, dj};
  assign match = dv && (span >= CNT_W'(4)) && (rd_data == cfg.first) &&
                 (b0 == cfg.second) && (b1 == 8'({1'b0, span - CNT_W'(4)})) &&
                 ((acc ^ b2) == 8'd0);

  assign k_last = (({1'b0, start} + {1'b0, k} + CNT_W'(1)) == fill);

  always_ff @(posedge clk) begin
    if (q_take && q_valid) begin
      win[wr_addr] <= q_byte;
    end
    rd_data <= win[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      iss_more  <= 1'b0;
      dv        <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != ST_WR)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (full) begin
              head  <= head + 1'b1;
              iss_j <= IDX_W'(WIN_DEPTH - 1);
            end else begin
              fill  <= fill + 1'b1;
              iss_j <= fill[IDX_W-1:0];
            end
            iss_more <= 1'b1;
            dv       <= 1'b0;
            b0       <= '0;
            b1       <= '0;
            b2       <= '0;
            acc      <= '0;
            found    <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // newest to oldest, one read a cycle; last hit is the earliest start
          dv <= iss_more;
          dj <= iss_j;
          if (iss_more) begin
            if (iss_j == '0) begin
              iss_more <= 1'b0;
            end else begin
              iss_j <= iss_j - 1'b1;
            end
          end
          if (dv) begin
            acc <= acc ^ b2;
            b2  <= b1;
            b1  <= b0;
            b0  <= rd_data;
            if (match) begin
              found <= 1'b1;
              start <= dj;
            end
            // issue already ended here, so dv drops on its own
            if (dj == '0) begin
              if (match || found) begin
                k     <= '0;
                state <= ST_RD;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_byte  <= rd_data;
            out_pos   <= 6'(k);
            out_last  <= k_last;
            if (k_last) begin
              fill  <= '0;
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.frame_byte    = out_byte;
  assign out_ch.byte_position = out_pos;
  assign out_ch.last_byte     = out_last;

  assign stat.idle = (state == ST_IDLE);
  assign stat.fill = fill;

endmodule

### hw/rtl/sync_length_xor_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_xor_deframer
// Receives bytes into a 64-byte window and emits each frame made of two sync
// bytes, a length byte L, L payload bytes and an XOR check byte.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      rx_byte[7:0]
//  out_ch   out  valid/ready      frame_byte[7:0], byte_position[5:0], last_byte
//  cfg      in   cfg_we (write)   cfg_idx[0], cfg_data[7:0]
//
//  Per byte: the byte is stored, then the window is scanned newest to oldest
//  (one window memory read a cycle) for a frame that ends on that byte.
//  A found frame is emitted byte by byte: read, then load output.
//  A 4-entry input queue takes bytes while the engine works.
//  Reset (rst, synchronous) empties the window and restores 0x27/0xA5 sync.
//  out_ch stalls hold the engine in emission; in_ch stalls only when full.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer import sld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_data,
  rx_if.sink                   in_ch,
  frame_if.source              out_ch
);

  sync_cfg_t  cfg;
  eng_stat_t  stat;
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first  <= SYNC_FIRST_RST;
      cfg.second <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SYNC_FIRST:  cfg.first  <= cfg_data;
        REG_SYNC_SECOND: cfg.second <= cfg_data;
        default: ;
      endcase
    end
  end

  sld_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_take  (q_take)
  );

  sld_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_take  (q_take),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    stat.fill <= CNT_W'(WIN_DEPTH))
    else $error("window fill above depth");

  // a new frame may follow at once, but it starts again at position 0
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last_byte |=>
      !out_ch.valid || (out_ch.byte_position == '0))
    else $error("frame continued after its last byte");

  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.last_byte |-> !stat.idle)
    else $error("engine idle in mid-frame");

endmodule

### dv/sync_length_xor_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_length_xor_deframer_tb
// Self-checking bench for the sync/length/XOR frame receiver. Received bytes
// are driven into in_ch while a scoreboard model of the 64-byte window works
// out which frame bytes must come out of out_ch. Directed frames, window
// limits, sync settings, output back-pressure and random traffic run in turn.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer_tb;
  import sld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = (Q_DEPTH + 2) * (WIN_DEPTH + 4);
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 40;
  localparam int CALM_ITEMS    = 15;   // tail of the random part, no idling
  localparam int MAX_PRINTS    = 100;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [5:0] pos;
    logic       is_last;
  } frame_item_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_data;

  rx_if    rx ();
  frame_if frm ();

  sync_length_xor_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (rx.sink),
    .out_ch   (frm.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scoreboard copy of the receiver
  logic [7:0]  sync_a = SYNC_FIRST_RST;
  logic [7:0]  sync_b = SYNC_SECOND_RST;
  logic [7:0]  win_bytes [WIN_DEPTH];
  int          win_fill = 0;
  frame_item_t pending_frame_bytes [$];

  int mismatches = 0;
  int bytes_sent = 0;
  bit gaps_on    = 1'b1;
  bit stall_on   = 1'b1;
  int hold_len   = 0;
  bit holding    = 1'b0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit frame_ends_at(input int s);
    logic [7:0] chk;
    int         plen;
    chk = '0;
    if (win_bytes[s] != sync_a || win_bytes[s+1] != sync_b) return 1'b0;
    plen = win_bytes[s+2];
    if (s + plen + 4 != win_fill) return 1'b0;
    for (int k = 0; k < plen; k++) chk ^= win_bytes[s+3+k];
    return chk == win_bytes[win_fill-1];
  endfunction

  // push one received byte; earliest frame ending here is emitted, window cleared
  function automatic void deframe_byte(input logic [7:0] b);
    int n;
    if (win_fill == WIN_DEPTH) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_bytes[i] = win_bytes[i+1];
      win_fill = WIN_DEPTH - 1;
    end
    win_bytes[win_fill] = b;
    win_fill++;
    for (int s = 0; s + 4 <= win_fill; s++) begin
      if (frame_ends_at(s)) begin
        n = win_fill - s;
        for (int k = 0; k < n; k++)
          pending_frame_bytes.push_back('{win_bytes[s+k], 6'(k), k == n - 1});
        win_fill = 0;
      end
    end
  endfunction

  // outputs checked before the input of the same edge is predicted
  always @(posedge clk) begin
    frame_item_t want;
    if (!rst) begin
      if (frm.valid && frm.ready) begin
        if (pending_frame_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte %02h pos %0d last %0b",
                                    frm.frame_byte, frm.byte_position, frm.last_byte));
        end else begin
          want = pending_frame_bytes.pop_front();
          if (frm.frame_byte !== want.fbyte)
            report_mismatch($sformatf("frame_byte got %02h want %02h",
                                      frm.frame_byte, want.fbyte));
          if (frm.byte_position !== want.pos)
            report_mismatch($sformatf("byte_position got %0d want %0d",
                                      frm.byte_position, want.pos));
          if (frm.last_byte !== want.is_last)
            report_mismatch($sformatf("last_byte got %0b want %0b",
                                      frm.last_byte, want.is_last));
        end
      end
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx.valid && rx.ready) || (frm.valid && frm.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // receiver: ready stretches, random stall bursts, and long hold-offs on request
  initial begin : receiver
    frm.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        holding = 1'b1;
        frm.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
        holding  = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        frm.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        frm.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk) rx.valid <= 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
    @(negedge clk);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    bytes_sent++;
  endtask

  // keep < 0 sends the whole frame, otherwise only its first keep bytes
  task automatic send_frame(input logic [7:0] s1, input logic [7:0] s2, input int plen,
                            input bit bad_check = 1'b0, input int keep = -1);
    logic [7:0] fb [$];
    logic [7:0] chk;
    chk = '0;
    fb  = {s1, s2, 8'(plen)};
    repeat (plen) begin
      fb.push_back(8'($urandom));
      chk ^= fb[$];
    end
    if (bad_check) chk ^= 8'(1 << $urandom_range(0, 7));
    fb.push_back(chk);
    if (keep < 0 || keep > fb.size()) keep = fb.size();
    for (int i = 0; i < keep; i++) send_byte(fb[i]);
  endtask

  // stop offering, wait for every frame byte, then let the input queue drain
  task automatic settle();
    @(negedge clk) rx.valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  sync_a = v;
      REG_SYNC_SECOND: sync_b = v;
      default: ;
    endcase
  endtask

  task automatic test_directed_frames();
    logic [7:0] seq [$];
    // bad check then empty frame (leading junk dropped), 00/FF payload,
    // then two frames ending on the same byte: the earlier start wins
    seq = {sync_a, sync_b, 8'h00, 8'h01,
           sync_a, sync_b, 8'h00, 8'h00,
           sync_a, sync_b, 8'h02, 8'h00, 8'hFF, 8'hFF,
           sync_a, sync_b, 8'h05, sync_a ^ sync_b ^ 8'h01,
           sync_a, sync_b, 8'h01, 8'hFF, 8'hFF};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_window_limits();
    repeat (2) send_byte(8'($urandom));
    send_frame(sync_a, sync_b, WIN_DEPTH - 4);        // window slides, positions up to 63
    send_frame(sync_a, sync_b, WIN_DEPTH - 3);        // one byte too long
    send_frame(sync_a, sync_b, 3);
  endtask

  task automatic run_sync_setting(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] old_a;
    logic [7:0] old_b;
    old_a = sync_a;
    old_b = sync_b;
    settle();
    write_sync_reg(REG_SYNC_FIRST, a);
    write_sync_reg(REG_SYNC_SECOND, b);
    send_frame(sync_a, sync_b, $urandom_range(0, 3));
    send_frame(old_a, old_b, $urandom_range(0, 3));
    send_frame(sync_b, sync_a, $urandom_range(0, 3));
    send_frame(sync_a, sync_b, $urandom_range(0, 3));
    send_frame(sync_a, sync_b, 0);
  endtask

  task automatic test_sync_settings();
    run_sync_setting(8'h00, 8'hFF);
    run_sync_setting(8'h5A, 8'h5A);
    run_sync_setting(8'($urandom), 8'($urandom));
  endtask

  task automatic test_output_backpressure();
    hold_len = HOLD_CYCLES;
    while (!holding) @(posedge clk);
    repeat (2) send_frame(sync_a, sync_b, 6);
    settle();
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int plen;
    write_sync_reg(REG_SYNC_FIRST, 8'($urandom));
    write_sync_reg(REG_SYNC_SECOND, 8'($urandom));
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      if (bytes_sent - start >= RANDOM_ITEMS - CALM_ITEMS) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, WIN_DEPTH - 4)
                                         : $urandom_range(0, 8);
      if (pick < 65)
        send_frame(sync_a, sync_b, plen);
      else if (pick < 75)
        send_frame(sync_a, sync_b, plen, 1'b1);
      else if (pick < 82)
        send_frame(sync_a, sync_b, plen, 1'b0, $urandom_range(1, plen + 3));
      else if (pick < 87)
        send_frame(sync_a, sync_b, $urandom_range(WIN_DEPTH - 3, 255), 1'b0,
                   $urandom_range(3, 12));
      else
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_idx    = REG_SYNC_FIRST;
    cfg_data   = '0;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed_frames();
    test_window_limits();
    test_sync_settings();
    test_output_backpressure();
    test_random_traffic();
    settle();

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
